[src/sle_pkg.sv]
package sle_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;
  localparam int unsigned BREAK_LEN        = 9;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_US  = 8'h1F;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    SRC_CHAR,
    SRC_CR,
    SRC_LF,
    SRC_DEL,
    SRC_BEL,
    SRC_BREAK,
    SRC_STORE,
    SRC_DONE
  } src_e;

  typedef enum logic [2:0] {
    CLS_EOL,
    CLS_ERASE,
    CLS_KILL,
    CLS_BREAK,
    CLS_PRINT,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_e;

  typedef struct packed {
    logic    take_char;
    logic    emit;
    src_e    src;
    kind_e   kind;
    logic    last;
    cnt_op_e cnt_op;
    logic    store_wr;
    logic    rd_en;
    logic    rd_next;
    logic    step_clr;
    logic    step_inc;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic empty;
    logic full;
    logic one_left;
    logic step_first;
    logic break_end;
    logic line_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] break_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      4'd0:    ch = 8'h3C;
      4'd1:    ch = 8'h62;
      4'd2:    ch = 8'h72;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h61;
      4'd5:    ch = 8'h6B;
      4'd6:    ch = 8'h3E;
      4'd7:    ch = CH_CR;
      4'd8:    ch = CH_LF;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/sle_rx_if.sv]
interface sle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

[src/sle_res_if.sv]
interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [4:0] line_length;
  logic       last;

  modport source (output valid, output kind, output out_char, output line_length,
                  output last, input ready);
  modport sink (input valid, input kind, input out_char, input line_length,
                input last, output ready);
endinterface

[src/serial_line_editor_top.sv]
// Line editor for a serial terminal.
// rx carries one received character per beat; res carries the answers: echo
// bytes (kind 0), the bytes of a finished line (kind 1) and a completion beat
// with the line length (kind 2); last marks the final beat of one character.
// cfg_we_i/cfg_wdata_i set the buffer size; write it only while idle.
// A character is taken when the controller is idle. A single echo or bell is
// loaded into the output register from the decode state, once the character
// register holds the rx beat; the first result of CR, LF, Control-U or
// Control-C is loaded from the state that follows the decode state. While res
// takes every beat, each further result is loaded in the next cycle, limited by
// the single output register and the one-read-per-cycle line store. rx is
// ready again in the cycle after the last result is loaded, while that result
// may still wait to be taken.
// When res is stalled the output register holds its beat and the controller
// waits; nothing is dropped.
// Reset empties the line and sets the buffer size to 32; the line store holds
// no reset value and only entries that were written are sent out.
module serial_line_editor_top #(
  parameter int unsigned BUFFER_DEPTH = sle_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_rx_if.sink     rx,
  sle_res_if.source  res,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);
  import sle_pkg::*;

  cmd_t    cmd;
  status_t st;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx.valid),
    .in_ready_o (rx.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sle_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .rx_char_i   (rx.rx_char),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (res.ready),
    .out_valid_o (res.valid),
    .out_kind_o  (res.kind),
    .out_char_o  (res.out_char),
    .out_len_o   (res.line_length),
    .out_last_o  (res.last)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> st.out_free)
    else $error("result loaded over an untaken beat");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_wr |-> !st.full && cmd.cnt_op == CNT_INC)
    else $error("character stored into a full line");

  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_op == CNT_DEC |-> !st.empty)
    else $error("erase on an empty line");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.kind == KIND_DONE |-> res.last)
    else $error("completion beat without last");

endmodule

[src/sle_dp.sv]
module sle_dp #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sle_pkg::cmd_t    cmd_i,
  output sle_pkg::status_t st_o,
  input  logic [7:0]       rx_char_i,
  input  logic             cfg_we_i,
  input  logic [5:0]       cfg_wdata_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_char_o,
  output logic [4:0]       out_len_o,
  output logic             out_last_o
);
  import sle_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [5:0] CapMax = (BUFFER_DEPTH - 1 > 31) ? 6'd31 : 6'(BUFFER_DEPTH - 1);

  logic [7:0]    mem_q [BUFFER_DEPTH];
  logic [7:0]    rd_q;
  logic [7:0]    char_q;
  logic [4:0]    fill_q, fill_d;
  logic [4:0]    step_q, step_d;
  logic [5:0]    limit_q;
  logic [5:0]    lim_m1, cap;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [7:0]    ochar_q, ochar_d;
  logic [4:0]    len_q;
  logic          last_q;
  logic          out_free;

  assign lim_m1   = (limit_q == 6'd0) ? 6'd0 : limit_q - 6'd1;
  assign cap      = (lim_m1 > CapMax) ? CapMax : lim_m1;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (char_q == CH_CR || char_q == CH_LF) begin
      st_o.cls = CLS_EOL;
    end else if (char_q == CH_DEL || char_q == CH_BS) begin
      st_o.cls = CLS_ERASE;
    end else if (char_q == CH_NAK) begin
      st_o.cls = CLS_KILL;
    end else if (char_q == CH_ETX) begin
      st_o.cls = CLS_BREAK;
    end else if (char_q > CH_US && char_q < CH_DEL) begin
      st_o.cls = CLS_PRINT;
    end else begin
      st_o.cls = CLS_OTHER;
    end
    st_o.empty      = (fill_q == 5'd0);
    st_o.full       = ({1'b0, fill_q} >= cap);
    st_o.one_left   = (fill_q == 5'd1);
    st_o.step_first = (step_q == 5'd0);
    st_o.break_end  = (step_q == 5'(BREAK_LEN - 1));
    st_o.line_last  = (step_q == fill_q - 5'd1);
    st_o.out_free   = out_free;
  end

  always_comb begin
    fill_d = fill_q;
    case (cmd_i.cnt_op)
      CNT_INC:   fill_d = fill_q + 5'd1;
      CNT_DEC:   fill_d = fill_q - 5'd1;
      CNT_CLEAR: fill_d = 5'd0;
      default:   fill_d = fill_q;
    endcase
    step_d = step_q;
    if (cmd_i.step_clr) begin
      step_d = 5'd0;
    end else if (cmd_i.step_inc) begin
      step_d = step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 5'd0;
      step_q  <= 5'd0;
      limit_q <= 6'd32;
    end else begin
      fill_q <= fill_d;
      step_q <= step_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char) begin
      char_q <= rx_char_i;
    end
  end

  // line store
  assign wr_addr = AW'(fill_q);
  assign rd_addr = cmd_i.rd_next ? AW'({1'b0, step_q} + 6'd1) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem_q[wr_addr] <= char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_CHAR:  ochar_d = char_q;
      SRC_CR:    ochar_d = CH_CR;
      SRC_LF:    ochar_d = CH_LF;
      SRC_DEL:   ochar_d = CH_DEL;
      SRC_BEL:   ochar_d = CH_BEL;
      SRC_BREAK: ochar_d = break_char(step_q[3:0]);
      SRC_STORE: ochar_d = rd_q;
      default:   ochar_d = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.kind;
      ochar_q <= ochar_d;
      len_q   <= (cmd_i.src == SRC_DONE) ? fill_q : 5'd0;
      last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_char_o  = ochar_q;
  assign out_len_o   = len_q;
  assign out_last_o  = last_q;

endmodule

[src/sle_ctrl.sv]
module sle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sle_pkg::status_t st_i,
  output sle_pkg::cmd_t    cmd_o
);
  import sle_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_NEWLINE = 3'd2;
  localparam logic [2:0] S_LINE    = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;
  localparam logic [2:0] S_KILL    = 3'd5;
  localparam logic [2:0] S_BREAK   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_char = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st_i.cls) inside
          CLS_EOL: begin
            cmd_o.step_clr = 1'b1;
            state_d        = S_NEWLINE;
          end
          CLS_ERASE: begin
            if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              if (st_i.empty) begin
                cmd_o.src = SRC_BEL;
              end else begin
                cmd_o.src    = SRC_DEL;
                cmd_o.cnt_op = CNT_DEC;
              end
              state_d = S_IDLE;
            end
          end
          CLS_KILL: begin
            state_d = st_i.empty ? S_IDLE : S_KILL;
          end
          CLS_BREAK: begin
            cmd_o.step_clr = 1'b1;
            cmd_o.cnt_op   = CNT_CLEAR;
            state_d        = S_BREAK;
          end
          CLS_PRINT, CLS_OTHER: begin
            if (st_i.full) begin
              if (st_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.last = 1'b1;
                cmd_o.src  = SRC_BEL;
                state_d    = S_IDLE;
              end
            end else if (st_i.cls == CLS_PRINT) begin
              if (st_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.last     = 1'b1;
                cmd_o.src      = SRC_CHAR;
                cmd_o.store_wr = 1'b1;
                cmd_o.cnt_op   = CNT_INC;
                state_d        = S_IDLE;
              end
            end else begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_NEWLINE: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (st_i.step_first) begin
            cmd_o.src      = SRC_CR;
            cmd_o.step_inc = 1'b1;
          end else begin
            cmd_o.src      = SRC_LF;
            cmd_o.rd_en    = 1'b1;
            cmd_o.step_clr = 1'b1;
            state_d        = st_i.empty ? S_DONE : S_LINE;
          end
        end
      end
      S_LINE: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_STORE;
          cmd_o.kind = KIND_LINE;
          if (st_i.line_last) begin
            state_d = S_DONE;
          end else begin
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_next  = 1'b1;
            cmd_o.step_inc = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.src    = SRC_DONE;
          cmd_o.kind   = KIND_DONE;
          cmd_o.last   = 1'b1;
          cmd_o.cnt_op = CNT_CLEAR;
          state_d      = S_IDLE;
        end
      end
      S_KILL: begin
        if (st_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.src    = SRC_DEL;
          cmd_o.cnt_op = CNT_DEC;
          if (st_i.one_left) begin
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_BREAK: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = SRC_BREAK;
          cmd_o.step_inc = 1'b1;
          if (st_i.break_end) begin
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
